// ===== sv/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, stage counts, the cofactor index table and the lane types of
// the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

   // matrix geometry and element widths
   localparam int LANES        = 9;
   localparam int ROW_LEN      = 3;
   localparam int ELEM_W       = 16;
   localparam int PROD_W       = 2 * ELEM_W;
   localparam int ADJ_W        = PROD_W + 1;
   localparam int DPROD_W      = ELEM_W + ADJ_W;
   localparam int DSUM_W       = DPROD_W + 1;
   localparam int DEN_W        = 48;
   localparam int Q_W          = 32;
   // numerator is |adj| shifted left by this many bits
   localparam int NUM_SHIFT    = 24;
   // bits of |adj| that drop below the first partial remainder
   localparam int LO_W         = Q_W - NUM_SHIFT;

   // pipeline depth
   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = Q_W + 1;
   localparam int TOTAL_STAGES = FRONT_STAGES + DIV_STAGES;

   // configuration port
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;
   localparam logic REG_DET_TOLERANCE = 1'b0;
   localparam logic [DEN_W-1:0] DET_TOL_RESET = 48'd17;

   // cofactor terms per adjugate entry: m[a]*m[b] - m[c]*m[d], index r*3+c
   localparam logic [3:0] COF_IDX [LANES][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // determinant side information handed from the front end to the lanes
   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic             det_neg;
      logic             invertible;
   } det_info_type;

   // what one divider lane found
   typedef struct packed {
      logic [Q_W-1:0] quot;
      logic           ovf;
      logic           neg;
      logic [Q_W-1:0] adj;
   } lane_res_type;

endpackage

// ===== sv/m3i_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline: products, adjugate, row-0 products,
// then determinant magnitude and the singularity test.
// ----------------------------------------------------------------------------
module m3i_front (
   input  logic                                                  clock,
   input  logic [m3i_pkg::FRONT_STAGES-1:0]                      adv,
   input  logic [m3i_pkg::LANES-1:0][m3i_pkg::ELEM_W-1:0]        mat,
   input  logic [m3i_pkg::DEN_W-1:0]                             tol,
   output logic [m3i_pkg::LANES-1:0][m3i_pkg::ADJ_W-1:0]         adj,
   output m3i_pkg::det_info_type                                 info
);

   logic signed [m3i_pkg::PROD_W-1:0]  prod_a_ff [m3i_pkg::LANES];
   logic signed [m3i_pkg::PROD_W-1:0]  prod_b_ff [m3i_pkg::LANES];
   logic signed [m3i_pkg::ELEM_W-1:0]  row0_ff   [m3i_pkg::ROW_LEN];
   logic signed [m3i_pkg::ELEM_W-1:0]  row1_ff   [m3i_pkg::ROW_LEN];
   logic signed [m3i_pkg::ADJ_W-1:0]   adj1_ff   [m3i_pkg::LANES];
   logic signed [m3i_pkg::ADJ_W-1:0]   adj2_ff   [m3i_pkg::LANES];
   logic        [m3i_pkg::ADJ_W-1:0]   adj3_ff   [m3i_pkg::LANES];
   logic signed [m3i_pkg::DPROD_W-1:0] dp_ff     [m3i_pkg::ROW_LEN];
   m3i_pkg::det_info_type              info_ff;
   m3i_pkg::det_info_type              info_in;
   logic signed [m3i_pkg::DSUM_W-1:0]  det_sum;
   logic        [m3i_pkg::DSUM_W-1:0]  det_abs;

   // form the 2x2 products of every cofactor
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int l = 0; l < m3i_pkg::LANES; l++) begin
            prod_a_ff[l] <= $signed(mat[m3i_pkg::COF_IDX[l][0]])
                          * $signed(mat[m3i_pkg::COF_IDX[l][1]]);
            prod_b_ff[l] <= $signed(mat[m3i_pkg::COF_IDX[l][2]])
                          * $signed(mat[m3i_pkg::COF_IDX[l][3]]);
         end
         for (int j = 0; j < m3i_pkg::ROW_LEN; j++) begin
            row0_ff[j] <= $signed(mat[j]);
         end
      end
   end

   // take the product differences
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int l = 0; l < m3i_pkg::LANES; l++) begin
            adj1_ff[l] <= m3i_pkg::ADJ_W'(prod_a_ff[l]) - m3i_pkg::ADJ_W'(prod_b_ff[l]);
         end
         row1_ff <= row0_ff;
      end
   end

   // expand along the first row: a0j * adj[j][0]
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int j = 0; j < m3i_pkg::ROW_LEN; j++) begin
            dp_ff[j] <= row1_ff[j] * adj1_ff[j * m3i_pkg::ROW_LEN];
         end
         adj2_ff <= adj1_ff;
      end
   end

   // sum, take the magnitude and test it against the tolerance
   always_comb begin
      det_sum = m3i_pkg::DSUM_W'(dp_ff[0]) + m3i_pkg::DSUM_W'(dp_ff[1])
              + m3i_pkg::DSUM_W'(dp_ff[2]);
      det_abs = det_sum[m3i_pkg::DSUM_W-1] ? m3i_pkg::DSUM_W'(-det_sum)
                                          : m3i_pkg::DSUM_W'(det_sum);
      info_in.den        = det_abs[m3i_pkg::DEN_W-1:0];
      info_in.det_neg    = det_sum[m3i_pkg::DSUM_W-1];
      info_in.invertible = det_abs > {{(m3i_pkg::DSUM_W - m3i_pkg::DEN_W){1'b0}}, tol};
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         info_ff <= info_in;
         for (int l = 0; l < m3i_pkg::LANES; l++) begin
            adj3_ff[l] <= adj2_ff[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < m3i_pkg::LANES; l++) begin
         adj[l] = adj3_ff[l];
      end
   end

   assign info = info_ff;

endmodule

// ===== sv/m3i_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div_lane
// One divider lane: (|adj| << 24) / |det| as a restoring divider, one quotient
// bit per stage, with an up-front overflow test for quotients of 2^32 and up.
// ----------------------------------------------------------------------------
module m3i_div_lane (
   input  logic                                               clock,
   input  logic [m3i_pkg::DIV_STAGES-1:0]                     adv,
   input  logic [m3i_pkg::ADJ_W-1:0]                          adj_in,
   input  logic [m3i_pkg::DEN_W-1:0]                          den_in,
   input  logic                                               det_neg_in,
   input  logic [m3i_pkg::DIV_STAGES-1:0][m3i_pkg::DEN_W-1:0] den_pipe,
   output m3i_pkg::lane_res_type                              res
);

   localparam int DW = m3i_pkg::DEN_W;
   localparam int QW = m3i_pkg::Q_W;
   localparam int CW = QW + DW - m3i_pkg::NUM_SHIFT;

   logic [DW-1:0]               rem_ff  [m3i_pkg::DIV_STAGES];
   logic [QW-1:0]               quot_ff [m3i_pkg::DIV_STAGES];
   logic [m3i_pkg::LO_W-1:0]    lo_ff   [m3i_pkg::DIV_STAGES];
   logic [QW-1:0]               adj_ff  [m3i_pkg::DIV_STAGES];
   logic                        ovf_ff  [m3i_pkg::DIV_STAGES];
   logic                        neg_ff  [m3i_pkg::DIV_STAGES];

   logic [m3i_pkg::ADJ_W-1:0]   adj_abs;
   logic [QW-1:0]               mag;
   logic                        ovf_in;

   // magnitude, sign and overflow: quotient >= 2^32 iff |adj| >= |det| << 8
   always_comb begin
      adj_abs = adj_in[m3i_pkg::ADJ_W-1] ? m3i_pkg::ADJ_W'(-$signed(adj_in)) : adj_in;
      mag     = adj_abs[QW-1:0];
      ovf_in  = {{(CW - QW){1'b0}}, mag} >= {den_in, {(CW - DW){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0]  <= DW'(mag >> m3i_pkg::LO_W);
         quot_ff[0] <= '0;
         lo_ff[0]   <= mag[m3i_pkg::LO_W-1:0];
         adj_ff[0]  <= adj_in[QW-1:0];
         ovf_ff[0]  <= ovf_in;
         neg_ff[0]  <= adj_in[m3i_pkg::ADJ_W-1] ^ det_neg_in;
      end
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar s = 1; s < m3i_pkg::DIV_STAGES; s++) begin : g_step
      localparam int K = QW - s;
      logic          nbit;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          fits;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      if (K >= m3i_pkg::NUM_SHIFT) begin : g_data
         assign nbit = lo_ff[s-1][K - m3i_pkg::NUM_SHIFT];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         trial   = {rem_ff[s-1], nbit};
         diff    = trial - {1'b0, den_pipe[s-1]};
         fits    = trial >= {1'b0, den_pipe[s-1]};
         rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
         quot_in = quot_ff[s-1];
         quot_in[K] = fits;
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            lo_ff[s]   <= lo_ff[s-1];
            adj_ff[s]  <= adj_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
         end
      end
   end

   always_comb begin
      res.quot = quot_ff[m3i_pkg::DIV_STAGES-1];
      res.ovf  = ovf_ff[m3i_pkg::DIV_STAGES-1];
      res.neg  = neg_ff[m3i_pkg::DIV_STAGES-1];
      res.adj  = adj_ff[m3i_pkg::DIV_STAGES-1];
   end

endmodule

// ===== sv/m3i_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_csr
// Register file of the inverse: the determinant tolerance, 48 bits at byte
// address 0 of an APB-style port with 64-bit data.
// ----------------------------------------------------------------------------
module m3i_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [m3i_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [m3i_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [m3i_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [m3i_pkg::DEN_W-1:0]        tol
);

   logic [m3i_pkg::DEN_W-1:0] tol_ff;
   logic                      sel_tol;

   // register index is the 8-byte slot
   assign sel_tol = paddr[m3i_pkg::CSR_ADDR_W-1] == m3i_pkg::REG_DET_TOLERANCE;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= m3i_pkg::DET_TOL_RESET;
      end else if (psel && penable && pwrite && sel_tol) begin
         tol_ff <= pwdata[m3i_pkg::DEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_tol) begin
         prdata = m3i_pkg::CSR_DATA_W'(tol_ff);
      end
   end

   assign pready = 1'b1;
   assign tol    = tol_ff;

endmodule

// ===== sv/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Fixed-point 3x3 inverse by cofactors with nine parallel divider lanes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one matrix per request: nine signed Q8.8 entries in tdata.
//   rsp_ returns nine signed Q16.16 entries in tdata and the invertible flag
//   in tuser. When |det| (Q24.24) is at or below the tolerance register, the
//   flag is 0 and tdata holds the raw adjugate instead of the inverse.
//   The csr_ port holds the 48-bit tolerance at byte address 0 (reset 17).
// Pipeline: cofactor and determinant stages, then the divider stages (one
//   overflow test, then one quotient bit per stage), then saturation into the
//   output register.
// Throughput: one matrix per cycle while the response side is not stalled;
//   the nine restoring dividers are fully pipelined, one stage per quotient bit.
// Reset clears all stage valid bits and the output valid flag; the tolerance
//   returns to 17. When rsp_tready is low, the result holds and the stages
//   behind it keep filling empty slots; req_tready drops only once every
//   stage is occupied.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
   input  logic                                  clock,
   input  logic                                  reset,
   // a_r0c0, a_r0c1, a_r0c2, a_r1c0, ... a_r2c2, 16 bits each, lowest first
   input  logic [143:0]                          req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // inv_r0c0, inv_r0c1, ... inv_r2c2, 32 bits each, lowest first
   output logic [287:0]                          rsp_tdata,
   // invertible
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [m3i_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [m3i_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [m3i_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int TS = m3i_pkg::TOTAL_STAGES;
   localparam int FS = m3i_pkg::FRONT_STAGES;
   localparam int DS = m3i_pkg::DIV_STAGES;
   localparam int QW = m3i_pkg::Q_W;

   logic [TS-1:0]                                 v_ff;
   logic [TS-1:0]                                 adv;
   logic                                          out_adv;
   logic                                          rsp_valid_ff;
   logic [287:0]                                  rsp_data_ff;
   logic [287:0]                                  rsp_data_in;
   logic                                          rsp_user_ff;
   logic [m3i_pkg::DEN_W-1:0]                     tol;
   logic [m3i_pkg::LANES-1:0][m3i_pkg::ELEM_W-1:0] mat;
   logic [m3i_pkg::LANES-1:0][m3i_pkg::ADJ_W-1:0]  adj;
   m3i_pkg::det_info_type                         info;
   logic [DS-1:0][m3i_pkg::DEN_W-1:0]             den_ff;
   logic [DS-1:0]                                 inv_ff;
   m3i_pkg::lane_res_type                         res [m3i_pkg::LANES];

   assign mat = req_tdata;

   // stage advance: a stage loads when it is empty or its successor moves
   always_comb begin
      out_adv = !rsp_valid_ff || rsp_tready;
      adv[TS-1] = !v_ff[TS-1] || out_adv;
      for (int i = TS - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < TS; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (out_adv) begin
            rsp_valid_ff <= v_ff[TS-1];
         end
      end
   end

   m3i_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .tol     (tol)
   );

   m3i_front u_front (
      .clock (clock),
      .adv   (adv[FS-1:0]),
      .mat   (mat),
      .tol   (tol),
      .adj   (adj),
      .info  (info)
   );

   // carry the divisor and the singularity flag alongside the lanes
   always_ff @(posedge clock) begin
      if (adv[FS]) begin
         den_ff[0] <= info.den;
         inv_ff[0] <= info.invertible;
      end
      for (int s = 1; s < DS; s++) begin
         if (adv[FS+s]) begin
            den_ff[s] <= den_ff[s-1];
            inv_ff[s] <= inv_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < m3i_pkg::LANES; l++) begin : g_lane
      m3i_div_lane u_lane (
         .clock      (clock),
         .adv        (adv[TS-1:FS]),
         .adj_in     (adj[l]),
         .den_in     (info.den),
         .det_neg_in (info.det_neg),
         .den_pipe   (den_ff),
         .res        (res[l])
      );
   end

   // merge lanes: saturate and sign each quotient, or pass the adjugate
   always_comb begin
      logic [QW-1:0] val;
      for (int l = 0; l < m3i_pkg::LANES; l++) begin
         if (!inv_ff[DS-1]) begin
            val = res[l].adj;
         end else if (res[l].neg) begin
            if (res[l].ovf || (res[l].quot[QW-1] && |res[l].quot[QW-2:0])) begin
               val = {1'b1, {(QW-1){1'b0}}};
            end else begin
               val = QW'(-res[l].quot);
            end
         end else begin
            if (res[l].ovf || res[l].quot[QW-1]) begin
               val = {1'b0, {(QW-1){1'b1}}};
            end else begin
               val = res[l].quot;
            end
         end
         rsp_data_in[l*QW +: QW] = val;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= inv_ff[DS-1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a receiver that takes results never sees the input side blocked
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request side stalled while response side is free");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a tolerance write lands in the register
   a_tol_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite
       && csr_paddr[m3i_pkg::CSR_ADDR_W-1] == m3i_pkg::REG_DET_TOLERANCE)
      |=> (tol == $past(csr_pwdata[m3i_pkg::DEN_W-1:0])))
      else $error("tolerance write lost");

endmodule
